// ----- hw/rtl/qts_pkg.sv -----
// Package for the quoted token scanner: result kinds, character constants,
// result structs and the ASCII character class functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qts_pkg;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,   // token character
      KIND_END  = 2'd1,   // token end, value is the terminator
      KIND_NONE = 2'd2    // no token, value is the character seen
   } kind_type;

   localparam logic [15:0] CH_NUL        = 16'h0000;
   localparam logic [15:0] CH_TAB        = 16'h0009;
   localparam logic [15:0] CH_CR         = 16'h000D;
   localparam logic [15:0] CH_SPACE      = 16'h0020;
   localparam logic [15:0] CH_QUOTE      = 16'h0022;
   localparam logic [15:0] CH_DOLLAR     = 16'h0024;
   localparam logic [15:0] CH_DASH       = 16'h002D;
   localparam logic [15:0] CH_DOT        = 16'h002E;
   localparam logic [15:0] CH_DIGIT_0    = 16'h0030;
   localparam logic [15:0] CH_DIGIT_9    = 16'h0039;
   localparam logic [15:0] CH_COLON      = 16'h003A;
   localparam logic [15:0] CH_UPPER_A    = 16'h0041;
   localparam logic [15:0] CH_UPPER_Z    = 16'h005A;
   localparam logic [15:0] CH_BACKSLASH  = 16'h005C;
   localparam logic [15:0] CH_UNDERSCORE = 16'h005F;
   localparam logic [15:0] CH_LOWER_A    = 16'h0061;
   localparam logic [15:0] CH_LOWER_Z    = 16'h007A;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] value;
      logic        last;
   } result_type;

   // results of one input word, up to two
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_out_type;

   function automatic logic is_space(input logic [15:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_word(input logic [15:0] c);
      return ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9))
          || ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z))
          || ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z))
          || (c == CH_UNDERSCORE) || (c == CH_DOLLAR) || (c == CH_DOT)
          || (c == CH_DASH) || (c == CH_COLON) || (c == CH_BACKSLASH);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/qts_scan.sv -----
// Scanner state (mode and held backslash) and the per-word decode logic.
// Depends on qts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qts_scan (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [15:0]           code_unit,
   output qts_pkg::step_out_type      step_out
);

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_QUOTED   = 2'd1,
      MODE_PENDING  = 2'd2,   // quote seen inside quoted token
      MODE_UNQUOTED = 2'd3
   } mode_type;

   mode_type mode_ff, mode_in;
   logic     held_ff, held_in;

   logic               bs_pre;
   logic               main_valid;
   qts_pkg::kind_type  main_kind;
   logic [15:0]        main_value;

   always_comb begin
      mode_in    = mode_ff;
      held_in    = 1'b0;
      main_valid = 1'b0;
      main_kind  = qts_pkg::KIND_CHAR;
      main_value = code_unit;
      bs_pre     = ((mode_ff == MODE_QUOTED) || (mode_ff == MODE_UNQUOTED)) && held_ff;

      if (bs_pre && (code_unit == qts_pkg::CH_BACKSLASH)) begin
         // doubled backslash: one backslash out, nothing else
         mode_in = mode_ff;
      end else begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (code_unit == qts_pkg::CH_NUL) begin
                  main_valid = 1'b1;
                  main_kind  = qts_pkg::KIND_NONE;
               end else if (qts_pkg::is_space(code_unit)) begin
                  main_valid = 1'b0;
               end else if (code_unit == qts_pkg::CH_QUOTE) begin
                  mode_in = MODE_QUOTED;
               end else if (qts_pkg::is_word(code_unit)) begin
                  mode_in = MODE_UNQUOTED;
                  if (code_unit == qts_pkg::CH_BACKSLASH) begin
                     held_in = 1'b1;
                  end else begin
                     main_valid = 1'b1;
                  end
               end else begin
                  main_valid = 1'b1;
                  main_kind  = qts_pkg::KIND_NONE;
               end
            end
            MODE_QUOTED: begin
               if (code_unit == qts_pkg::CH_NUL) begin
                  main_valid = 1'b1;
                  main_kind  = qts_pkg::KIND_END;
                  mode_in    = MODE_IDLE;
               end else if (code_unit == qts_pkg::CH_QUOTE) begin
                  mode_in = MODE_PENDING;
               end else if (code_unit == qts_pkg::CH_BACKSLASH) begin
                  held_in = 1'b1;
               end else begin
                  main_valid = 1'b1;
               end
            end
            MODE_PENDING: begin
               main_valid = 1'b1;
               if (code_unit == qts_pkg::CH_QUOTE) begin
                  mode_in = MODE_QUOTED;     // doubled quote stands for one
               end else begin
                  main_kind = qts_pkg::KIND_END;
                  mode_in   = MODE_IDLE;
               end
            end
            MODE_UNQUOTED: begin
               if ((code_unit != qts_pkg::CH_NUL) && qts_pkg::is_word(code_unit)) begin
                  if (code_unit == qts_pkg::CH_BACKSLASH) begin
                     held_in = 1'b1;
                  end else begin
                     main_valid = 1'b1;
                  end
               end else begin
                  main_valid = 1'b1;
                  main_kind  = qts_pkg::KIND_END;
                  mode_in    = MODE_IDLE;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   // assemble up to two results, held backslash first
   always_comb begin
      step_out.first.kind   = qts_pkg::KIND_CHAR;
      step_out.first.value  = qts_pkg::CH_BACKSLASH;
      step_out.first.last   = 1'b1;
      step_out.second.kind  = main_kind;
      step_out.second.value = main_value;
      step_out.second.last  = 1'b1;
      step_out.count        = 2'd0;
      if (bs_pre) begin
         step_out.first.last = ~main_valid;
         step_out.count      = main_valid ? 2'd2 : 2'd1;
      end else begin
         step_out.first.kind  = main_kind;
         step_out.first.value = main_value;
         step_out.count       = {1'b0, main_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         held_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/quoted_token_scanner.sv -----
// Top level of the quoted token scanner: stream ports, scanner and a
// two-entry result buffer. Depends on qts_pkg and qts_scan.
//
// Usage:
//   req_ channel carries one 16-bit character per word; code 0 ends the line.
//   rsp_ channel carries the results: rsp_tuser is the kind (token char,
//   token end, no token), rsp_tdata the character or terminator, and
//   rsp_tlast marks the final result caused by one input word.
//   Each input word gives zero, one or two results. A word is decoded in the
//   cycle it is accepted and its results sit in the result buffer from the
//   next cycle on. Throughput: one word per cycle while each gives at most
//   one result and the receiver keeps rsp_tready high; a word that gives two
//   results (held backslash followed by another character) holds off the
//   next word until its first result is taken, as the single result port
//   drains the two-entry buffer.
//   req_tready is high when the buffer is empty or will be empty after the
//   result shown now is taken, so a stalled receiver holds off the sender
//   without losing or reordering results.
//   Reset (synchronous, active high) returns the scanner to idle with no
//   held backslash and empties the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module quoted_token_scanner (
   input  wire logic        clock,
   input  wire logic        reset,
   // input words
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,    // [15:0] code_unit
   // result words
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,    // [15:0] value
   output      logic [1:0]  rsp_tuser,    // [1:0] kind
   output      logic        rsp_tlast     // last result of an input word
);

   logic                   req_accept;
   logic                   rsp_pop;
   qts_pkg::step_out_type  step_out;

   logic [1:0]             count_ff;
   qts_pkg::result_type    head_ff;
   qts_pkg::result_type    tail_ff;

   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   qts_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .code_unit (req_tdata),
      .step_out  (step_out)
   );

   // buffer is empty (or emptying) whenever a word is accepted, so a load
   // simply replaces both entries
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (req_accept) begin
         count_ff <= step_out.count;
      end else if (rsp_pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         head_ff <= step_out.first;
         tail_ff <= step_out.second;
      end else if (rsp_pop) begin
         head_ff <= tail_ff;
      end
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = head_ff.value;
   assign rsp_tuser  = head_ff.kind;
   assign rsp_tlast  = head_ff.last;

endmodule

`default_nettype wire

// ----- hw/rtl/qts_checker.sv -----
// Port-level checks for the quoted token scanner, bound to the top level.
// Depends on qts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // nothing to show right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result shown after reset");

   // a stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // only a held backslash can precede another result of the same word
   a_first_of_two: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         rsp_tuser == qts_pkg::KIND_CHAR && rsp_tdata == qts_pkg::CH_BACKSLASH)
      else $error("non-final result is not a backslash");

   // markers always close the word's results
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == qts_pkg::KIND_END || rsp_tuser == qts_pkg::KIND_NONE)
         |-> rsp_tlast)
      else $error("marker not last");

   // a non-final backslash is followed directly by the rest of its word
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("second result of a word missing");

endmodule

bind quoted_token_scanner qts_checker u_qts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ----- verif/quoted_token_scanner_tb.sv -----
// Self-checking testbench for quoted_token_scanner: directed lines, random
// token lines and noise, with stalls on both stream sides and a predictor of
// its own. Depends on qts_pkg and the quoted_token_scanner RTL only.
`timescale 1ns / 1ps

module quoted_token_scanner_tb;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   // scanner state as the predictor tracks it
   typedef enum logic [1:0] {
      SCAN_IDLE,        // skipping whitespace
      SCAN_QUOTED,      // inside "..."
      SCAN_QUOTE_SEEN,  // quote seen inside "...", close or doubled quote
      SCAN_BARE         // inside an unquoted token
   } scan_state_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   scan_state_type      scan_st  = SCAN_IDLE;
   logic                bs_held  = 1'b0;
   qts_pkg::result_type token_q[$];        // predicted results, oldest first

   int errors      = 0;
   int words_sent  = 0;
   int idle_cycles = 0;
   int rx_hold     = 0;
   bit tx_idle_en  = 1'b0;
   bit rx_idle_en  = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   quoted_token_scanner u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ---------------------------------------------------------------------
   // Character classes, ASCII only; anything at or above 0x80 is neither
   // ---------------------------------------------------------------------
   function automatic bit is_blank(input logic [15:0] c);
      return (c == qts_pkg::CH_SPACE) || (c >= qts_pkg::CH_TAB && c <= qts_pkg::CH_CR);
   endfunction

   function automatic bit is_token_char(input logic [15:0] c);
      if (c >= 16'h0080) return 1'b0;
      if (c >= qts_pkg::CH_DIGIT_0 && c <= qts_pkg::CH_DIGIT_9) return 1'b1;
      if (c >= qts_pkg::CH_UPPER_A && c <= qts_pkg::CH_UPPER_Z) return 1'b1;
      if (c >= qts_pkg::CH_LOWER_A && c <= qts_pkg::CH_LOWER_Z) return 1'b1;
      return c == qts_pkg::CH_UNDERSCORE || c == qts_pkg::CH_DOLLAR ||
             c == qts_pkg::CH_DOT || c == qts_pkg::CH_DASH ||
             c == qts_pkg::CH_COLON || c == qts_pkg::CH_BACKSLASH;
   endfunction

   function automatic qts_pkg::result_type mk_result(input qts_pkg::kind_type k,
                                                     input logic [15:0] v);
      qts_pkg::result_type r;
      r.kind  = k;
      r.value = v;
      r.last  = 1'b0;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Predictor: advances the scanner state for one accepted word and queues
   // the zero, one or two results it gives, last flag on the final one.
   // ---------------------------------------------------------------------
   task automatic predict_tokens(input logic [15:0] c);
      qts_pkg::result_type outs[2];
      int                  n;
      bit                  done;
      n    = 0;
      done = 1'b0;
      // a held backslash comes out first; a second backslash is swallowed
      if ((scan_st == SCAN_QUOTED || scan_st == SCAN_BARE) && bs_held) begin
         bs_held = 1'b0;
         outs[n] = mk_result(qts_pkg::KIND_CHAR, qts_pkg::CH_BACKSLASH);
         n++;
         done = (c == qts_pkg::CH_BACKSLASH);
      end
      if (!done) begin
         case (scan_st)
            SCAN_IDLE: begin
               bs_held = 1'b0;
               if (c == qts_pkg::CH_NUL) begin
                  outs[n] = mk_result(qts_pkg::KIND_NONE, qts_pkg::CH_NUL);
                  n++;
               end else if (is_blank(c)) begin
                  // leading whitespace, nothing out
               end else if (c == qts_pkg::CH_QUOTE) begin
                  scan_st = SCAN_QUOTED;
               end else if (is_token_char(c)) begin
                  scan_st = SCAN_BARE;
                  if (c == qts_pkg::CH_BACKSLASH) begin
                     bs_held = 1'b1;
                  end else begin
                     outs[n] = mk_result(qts_pkg::KIND_CHAR, c);
                     n++;
                  end
               end else begin
                  outs[n] = mk_result(qts_pkg::KIND_NONE, c);
                  n++;
               end
            end
            SCAN_QUOTED: begin
               if (c == qts_pkg::CH_NUL) begin
                  outs[n] = mk_result(qts_pkg::KIND_END, qts_pkg::CH_NUL);
                  n++;
                  scan_st = SCAN_IDLE;
               end else if (c == qts_pkg::CH_QUOTE) begin
                  scan_st = SCAN_QUOTE_SEEN;
               end else if (c == qts_pkg::CH_BACKSLASH) begin
                  bs_held = 1'b1;
               end else begin
                  outs[n] = mk_result(qts_pkg::KIND_CHAR, c);
                  n++;
               end
            end
            SCAN_QUOTE_SEEN: begin
               bs_held = 1'b0;
               if (c == qts_pkg::CH_QUOTE) begin
                  outs[n] = mk_result(qts_pkg::KIND_CHAR, qts_pkg::CH_QUOTE);
                  n++;
                  scan_st = SCAN_QUOTED;
               end else begin
                  // closing quote: this word is the terminator, even 0
                  outs[n] = mk_result(qts_pkg::KIND_END, c);
                  n++;
                  scan_st = SCAN_IDLE;
               end
            end
            default: begin
               if (c != qts_pkg::CH_NUL && is_token_char(c)) begin
                  if (c == qts_pkg::CH_BACKSLASH) begin
                     bs_held = 1'b1;
                  end else begin
                     outs[n] = mk_result(qts_pkg::KIND_CHAR, c);
                     n++;
                  end
               end else begin
                  outs[n] = mk_result(qts_pkg::KIND_END, c);
                  n++;
                  scan_st = SCAN_IDLE;
               end
            end
         endcase
      end
      if (n > 0) outs[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) token_q.push_back(outs[i]);
   endtask

   task automatic report_mismatch(input string field, input logic [15:0] want,
                                  input logic [15:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // Result check and input tap, both on handshakes seen at the edge.
   // Results of a word accepted at this edge cannot also be taken here, so
   // checking before predicting keeps the queue order right.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      qts_pkg::result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (token_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, %s %0d value %h last %b",
                        $time, "actual kind", rsp_tuser, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               want = token_q.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch("kind", 16'(want.kind), 16'(rsp_tuser));
               if (rsp_tdata !== want.value)
                  report_mismatch("value", want.value, rsp_tdata);
               if (rsp_tlast !== want.last)
                  report_mismatch("last", 16'(want.last), 16'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) predict_tokens(req_tdata);
      end
   end

   // watchdog: cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // receiver: ready unless serving a random stall
   always @(posedge clock) begin
      if (rx_hold != 0) begin
         rsp_tready <= 1'b0;
         rx_hold    <= rx_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (rx_idle_en && $urandom_range(99) < 30) rx_hold <= pick_gap();
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [15:0] c);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      gap = tx_idle_en ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every predicted result has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (token_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] word_char();
      int r;
      r = $urandom_range(71);
      if (r < 10) return qts_pkg::CH_DIGIT_0 + 16'(r);
      if (r < 36) return qts_pkg::CH_UPPER_A + 16'(r - 10);
      if (r < 62) return qts_pkg::CH_LOWER_A + 16'(r - 36);
      case (r)
         62:      return qts_pkg::CH_UNDERSCORE;
         63:      return qts_pkg::CH_DOLLAR;
         64:      return qts_pkg::CH_DOT;
         65:      return qts_pkg::CH_DASH;
         66:      return qts_pkg::CH_COLON;
         default: return qts_pkg::CH_BACKSLASH;   // weighted up, backslash pairs matter
      endcase
   endfunction

   // terminator after a token: mostly whitespace, sometimes anything
   function automatic logic [15:0] sep_char();
      int r;
      r = $urandom_range(99);
      if (r < 50) return qts_pkg::CH_SPACE;
      if (r < 70) return 16'($urandom_range(qts_pkg::CH_CR, qts_pkg::CH_TAB));
      if (r < 78) return qts_pkg::CH_NUL;
      if (r < 90) return 16'($urandom_range(16'h007F, 16'h0021));
      return 16'($urandom_range(16'hFFFF, 16'h0080));
   endfunction

   // one command line: leading blanks, a few tokens, end of line
   task automatic send_line();
      int          r;
      int          len;
      logic [15:0] c;
      repeat ($urandom_range(2)) send_word(qts_pkg::CH_SPACE);
      repeat ($urandom_range(4)) begin
         r   = $urandom_range(9);
         len = $urandom_range(6);
         if (r < 4) begin
            send_word(qts_pkg::CH_QUOTE);
            repeat (len) begin
               r = $urandom_range(99);
               if (r < 40)      c = word_char();
               else if (r < 55) c = qts_pkg::CH_SPACE;
               else if (r < 70) c = qts_pkg::CH_QUOTE;
               else if (r < 80) c = qts_pkg::CH_BACKSLASH;
               else             c = 16'($urandom_range(16'hFFFF, 16'h0001));
               send_word(c);
               // a lone quote here closes the token early
               if (c == qts_pkg::CH_QUOTE && $urandom_range(9) != 0)
                  send_word(qts_pkg::CH_QUOTE);
            end
            // now and then the line ends inside the quotes
            if ($urandom_range(9) != 0) send_word(qts_pkg::CH_QUOTE);
         end else if (r < 8) begin
            repeat (len + 1) send_word(word_char());
         end else begin
            send_word(16'($urandom_range(16'h007F, 16'h0021)));
         end
         send_word(sep_char());
      end
      send_word(qts_pkg::CH_NUL);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      logic [15:0] seq[$];
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      seq = '{
         // idle: end of line, blanks at both ends of the range, non-token starts
         qts_pkg::CH_NUL, qts_pkg::CH_SPACE, qts_pkg::CH_TAB, qts_pkg::CH_CR,
         16'h0021, 16'hFFFF, 16'h0080,
         // bare token: doubled backslash, held backslash then end of line
         qts_pkg::CH_UNDERSCORE, qts_pkg::CH_BACKSLASH, qts_pkg::CH_BACKSLASH,
         qts_pkg::CH_LOWER_Z, qts_pkg::CH_BACKSLASH, qts_pkg::CH_NUL,
         // quoted: held backslash then char, doubled quote, held backslash
         // then quote, closed by a top code unit
         qts_pkg::CH_QUOTE, qts_pkg::CH_BACKSLASH, 16'h0051, qts_pkg::CH_QUOTE,
         qts_pkg::CH_QUOTE, qts_pkg::CH_BACKSLASH, qts_pkg::CH_QUOTE, 16'hFFFF,
         // quote right before end of line
         qts_pkg::CH_QUOTE, qts_pkg::CH_UPPER_A, qts_pkg::CH_QUOTE, qts_pkg::CH_NUL,
         // end of line inside quotes
         qts_pkg::CH_QUOTE, qts_pkg::CH_NUL
      };
      foreach (seq[i]) send_word(seq[i]);
   endtask

   task automatic test_lines_steady(input int count);
      int target;
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      target     = words_sent + count;
      while (words_sent < target) send_line();
   endtask

   task automatic test_lines_idling(input int count);
      int target;
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      target     = words_sent + count;
      while (words_sent < target) send_line();
   endtask

   // lines with the sender pausing until the scanner has fully drained
   task automatic test_drained_restart(input int count);
      int target;
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b1;
      target     = words_sent + count;
      while (words_sent < target) begin
         send_line();
         wait_drained();
      end
   endtask

   // random words and broken sequences
   task automatic test_noise(input int count);
      int r;
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 45)      send_word(16'($urandom_range(16'hFFFF, 16'h0000)));
         else if (r < 60) send_word(qts_pkg::CH_QUOTE);
         else if (r < 72) send_word(qts_pkg::CH_BACKSLASH);
         else if (r < 80) send_word(qts_pkg::CH_NUL);
         else if (r < 88) send_word(qts_pkg::CH_SPACE);
         else             send_word(word_char());
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_lines_steady(250);
      test_lines_idling(550);
      test_drained_restart(150);
      test_noise(250);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
